FILE: sv/twram_pkg.sv
// Shared types and constants for the three-wire register access master.
// No dependencies; imported by the front, the sequencer and the top level.
`default_nettype none

package twram_pkg;

  // Header is one byte: read flag in the top bit, register number below
  localparam int unsigned ADDR_BITS = 8;
  localparam int unsigned REG_BITS  = 7;
  localparam int unsigned WORD_BITS = 16;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd10;

  // Access kind as carried in the request
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    logic                   start;
    logic [ADDR_BITS-1:0]   header;
    logic [WORD_BITS-1:0]   wdata;
    logic                   sda;
  } item_t;

  // Queue to sequencer handshake
  typedef struct packed {
    logic valid;
  } q_status_t;

  // Bus sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_LOW  = 3'd1,
    PH_SEND_HIGH = 3'd2,
    PH_GAP       = 3'd3,
    PH_RECV_LOW  = 3'd4,
    PH_RECV_HIGH = 3'd5
  } phase_t;

endpackage

`default_nettype wire

FILE: sv/three_wire_register_access_master.sv
// Three-wire serial register bus master, top level.
// A request passes the queue slot and then the sequencer state registers.
// One request per cycle unless the queue is full; one bus tick per pop.
// A two-entry queue separates the front from the sequencer.
// Reset (synchronous, rst_n low): idle, chip select high, SDA driven low,
// half period 10. Depends on twram_pkg, twram_front and twram_seq.
`default_nettype none

module three_wire_register_access_master #(
  parameter int unsigned DATA_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data,
  input  wire logic         in_valid,
  output      logic         in_stall,
  input  wire logic         in_start_req,
  input  wire logic         in_kind,
  input  wire logic [6:0]   in_reg_addr,
  input  wire logic [15:0]  in_write_data,
  input  wire logic         in_sda_in,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output      logic         out_scl,
  output      logic         out_sda_out,
  output      logic         out_sda_drive,
  output      logic         out_cs_n,
  output      logic         out_busy_res,
  output      logic [15:0]  out_read_data,
  output      logic         out_read_done
);
  import twram_pkg::*;

  q_status_t q_status;
  item_t     q_item;
  logic      pop;

  // Request queue
  twram_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_kind       (in_kind),
    .in_reg_addr   (in_reg_addr),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .pop           (pop),
    .q_status      (q_status),
    .q_item        (q_item)
  );

  // Bus sequencer
  twram_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_status      (q_status),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl       (out_scl),
    .out_sda_out   (out_sda_out),
    .out_sda_drive (out_sda_drive),
    .out_cs_n      (out_cs_n),
    .out_busy_res  (out_busy_res),
    .out_read_data (out_read_data),
    .out_read_done (out_read_done)
  );

endmodule

`default_nettype wire

FILE: sv/twram_front.sv
// Front end: takes requests, builds the header byte and the payload word,
// and holds them in a two-entry queue for the sequencer. Uses twram_pkg.
`default_nettype none

module twram_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic                      in_start_req,
  input  wire logic                      in_kind,
  input  wire logic [6:0]                in_reg_addr,
  input  wire logic [15:0]               in_write_data,
  input  wire logic                      in_sda_in,
  input  wire logic                      pop,
  output      twram_pkg::q_status_t      q_status,
  output      twram_pkg::item_t          q_item
);
  import twram_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  item_t      cls_item;

  // Classify: header carries the read flag, reads send no payload
  always_comb begin
    cls_item.start  = in_start_req;
    cls_item.header = {in_kind, in_reg_addr};
    cls_item.wdata  = (in_kind == KIND_READ) ? '0 : in_write_data;
    cls_item.sda    = in_sda_in;
  end

  assign in_stall       = (count_r == 2'd2);
  assign push           = in_valid && !in_stall;
  assign q_status.valid = (count_r != 2'd0);
  assign q_item         = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/twram_seq.sv
// Back end: bus sequencer that advances one tick per request and whose
// state registers form the result register. Uses twram_pkg.
`default_nettype none

module twram_seq #(
  parameter int unsigned DATA_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [7:0]             cfg_wr_data,
  input  wire twram_pkg::q_status_t   q_status,
  input  wire twram_pkg::item_t       q_item,
  output      logic                   pop,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic                   out_scl,
  output      logic                   out_sda_out,
  output      logic                   out_sda_drive,
  output      logic                   out_cs_n,
  output      logic                   out_busy_res,
  output      logic [15:0]            out_read_data,
  output      logic                   out_read_done
);
  import twram_pkg::*;

  localparam int unsigned SW  = ADDR_BITS + DATA_BITS;
  localparam int unsigned BCW = $clog2(SW + 1);
  localparam logic [BCW-1:0] HDR_CNT  = BCW'(ADDR_BITS);
  localparam logic [BCW-1:0] FULL_CNT = BCW'(SW);
  localparam logic [BCW-1:0] DATA_CNT = BCW'(DATA_BITS);

  phase_t          phase_r, phase_nxt;
  logic [BCW-1:0]  bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [SW-1:0]   shift_r, shift_nxt, shift_up;
  logic [7:0]      tick_r, tick_nxt;
  logic [7:0]      half_r;
  logic [15:0]     rword_r, rword_nxt;
  logic            rflag_r, rflag_nxt;
  logic            is_read_r, is_read_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            drv_r, drv_nxt;
  logic            cs_r, cs_nxt;
  logic            out_valid_r;
  logic            busy, adv, go;

  // Take the next tick whenever the result slot is free or being drained
  assign pop  = q_status.valid && (!out_valid_r || !out_stall);
  assign busy = (phase_r != PH_IDLE);
  assign adv  = busy && (({1'b0, tick_r} + 9'd1) >= {1'b0, half_r});
  assign go   = !busy && q_item.start;

  assign bit_inc  = bit_cnt_r + BCW'(1);
  assign shift_up = {shift_r[SW-2:0], 1'b0};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      phase_nxt = PH_SEND_LOW;
    end else if (adv) begin
      unique case (phase_r)
        PH_SEND_LOW:  phase_nxt = PH_SEND_HIGH;
        PH_SEND_HIGH: begin
          if (is_read_r && (bit_inc >= HDR_CNT)) begin
            phase_nxt = PH_GAP;
          end else if (!is_read_r && (bit_inc >= FULL_CNT)) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_SEND_LOW;
          end
        end
        PH_GAP:       phase_nxt = PH_RECV_LOW;
        PH_RECV_LOW:  phase_nxt = (bit_cnt_r >= DATA_CNT) ? PH_IDLE : PH_RECV_HIGH;
        PH_RECV_HIGH: phase_nxt = PH_RECV_LOW;
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Datapath and pin updates for this tick
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    rword_nxt   = rword_r;
    rflag_nxt   = 1'b0;
    is_read_nxt = is_read_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    drv_nxt     = drv_r;
    cs_nxt      = cs_r;
    if (go) begin
      is_read_nxt = q_item.header[ADDR_BITS-1];
      shift_nxt   = {q_item.header, DATA_BITS'(q_item.wdata)};
      bit_cnt_nxt = '0;
      tick_nxt    = '0;
      cs_nxt      = 1'b0;
      drv_nxt     = 1'b1;
      scl_nxt     = 1'b0;
      sda_nxt     = q_item.header[ADDR_BITS-1];
    end else if (busy && !adv) begin
      tick_nxt = tick_r + 8'd1;
    end else if (adv) begin
      tick_nxt = '0;
      unique case (phase_r)
        PH_SEND_LOW:  scl_nxt = 1'b1;
        PH_SEND_HIGH: begin
          bit_cnt_nxt = bit_inc;
          shift_nxt   = shift_up;
          if (is_read_r && (bit_inc >= HDR_CNT)) begin
            // hold pins through the turnaround phase
          end else if (!is_read_r && (bit_inc >= FULL_CNT)) begin
            cs_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            sda_nxt = shift_r[SW-2];
          end
        end
        PH_GAP: begin
          drv_nxt     = 1'b0;
          scl_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
        end
        PH_RECV_LOW: begin
          if (bit_cnt_r >= DATA_CNT) begin
            rword_nxt = 16'(shift_r[DATA_BITS-1:0]);
            rflag_nxt = 1'b1;
            cs_nxt    = 1'b1;
          end else begin
            scl_nxt     = 1'b1;
            shift_nxt   = {shift_r[SW-2:0], q_item.sda};
            bit_cnt_nxt = bit_inc;
          end
        end
        PH_RECV_HIGH: scl_nxt = 1'b0;
        default:      cs_nxt  = 1'b1;
      endcase
    end
  end

  // Sequencer state, advanced once per request taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      tick_r    <= '0;
      rword_r   <= '0;
      rflag_r   <= 1'b0;
      is_read_r <= 1'b0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      drv_r     <= 1'b1;
      cs_r      <= 1'b1;
    end else if (pop) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      tick_r    <= tick_nxt;
      rword_r   <= rword_nxt;
      rflag_r   <= rflag_nxt;
      is_read_r <= is_read_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      drv_r     <= drv_nxt;
      cs_r      <= cs_nxt;
    end
  end

  // Half period register and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_PERIOD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        half_r <= cfg_wr_data;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result is the state left by the last tick
  assign out_valid     = out_valid_r;
  assign out_scl       = scl_r;
  assign out_sda_out   = sda_r;
  assign out_sda_drive = drv_r;
  assign out_cs_n      = cs_r;
  assign out_busy_res  = busy;
  assign out_read_data = rword_r;
  assign out_read_done = rflag_r;

endmodule

`default_nettype wire

FILE: bench/three_wire_register_access_master_tb.sv
// Self-checking bench for three_wire_register_access_master: every accepted tick
// is run through a local bus sequencer model and the pin levels are checked.
// Depends on twram_pkg and the RTL of three_wire_register_access_master.
`timescale 1ns / 1ps

module three_wire_register_access_master_tb;
  import twram_pkg::*;

  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int SDA_LOW       = 0;
  localparam int SDA_HIGH      = 1;
  localparam int SDA_RANDOM    = 2;
  localparam int SLOW_TICKS    = 260;

  // One tick request as seen on the input channel
  typedef struct packed {
    logic        start;
    logic        kind;
    logic [6:0]  addr;
    logic [15:0] wdata;
    logic        sda;
  } tick_req_t;

  // Pin levels and read status reported for one tick
  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        cs_n;
    logic        busy;
    logic [15:0] rdata;
    logic        rdone;
  } pin_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_start_req;
  logic        in_kind;
  logic [6:0]  in_reg_addr;
  logic [15:0] in_write_data;
  logic        in_sda_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_sda_drive;
  logic        out_cs_n;
  logic        out_busy_res;
  logic [15:0] out_read_data;
  logic        out_read_done;

  // Idling controls and the long receiver hold-off
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   mismatch_count = 0;

  // Sequencer model state
  phase_t      bus_phase;
  logic [4:0]  bits_done;
  logic [23:0] shifter;
  logic [7:0]  ticks;
  logic [7:0]  half_ticks;
  logic [15:0] last_read;
  logic        done_flag;
  logic        reading;
  logic        pin_scl;
  logic        pin_sda;
  logic        pin_drv;
  logic        pin_cs;

  pin_state_t  expected_pins[$];

  three_wire_register_access_master u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_kind       (in_kind),
    .in_reg_addr   (in_reg_addr),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl       (out_scl),
    .out_sda_out   (out_sda_out),
    .out_sda_drive (out_sda_drive),
    .out_cs_n      (out_cs_n),
    .out_busy_res  (out_busy_res),
    .out_read_data (out_read_data),
    .out_read_done (out_read_done)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Advance the bus model by one tick and return the pin levels after it
  task automatic advance_bus_tick(input tick_req_t req, output pin_state_t res);
    begin
      done_flag = 1'b0;
      if (bus_phase == PH_IDLE) begin
        if (req.start) begin
          reading   = (req.kind == KIND_READ);
          shifter   = {req.kind, req.addr, (req.kind == KIND_READ) ? 16'h0000 : req.wdata};
          bits_done = '0;
          ticks     = '0;
          pin_cs    = 1'b0;
          pin_drv   = 1'b1;
          pin_scl   = 1'b0;
          pin_sda   = shifter[23];
          bus_phase = PH_SEND_LOW;
        end
      end else if (int'(ticks) + 1 < int'(half_ticks)) begin
        ticks = ticks + 8'd1;
      end else begin
        ticks = '0;
        case (bus_phase)
          PH_SEND_LOW: begin
            pin_scl   = 1'b1;
            bus_phase = PH_SEND_HIGH;
          end
          PH_SEND_HIGH: begin
            bits_done = bits_done + 5'd1;
            shifter   = shifter << 1;
            if (reading && bits_done >= ADDR_BITS) begin
              bus_phase = PH_GAP;
            end else if (!reading && bits_done >= ADDR_BITS + WORD_BITS) begin
              pin_cs    = 1'b1;
              bus_phase = PH_IDLE;
            end else begin
              pin_scl   = 1'b0;
              pin_sda   = shifter[23];
              bus_phase = PH_SEND_LOW;
            end
          end
          PH_GAP: begin
            // turn-around: release SDA before clocking the word in
            pin_drv   = 1'b0;
            pin_scl   = 1'b0;
            bits_done = '0;
            shifter   = '0;
            bus_phase = PH_RECV_LOW;
          end
          PH_RECV_LOW: begin
            if (bits_done >= WORD_BITS) begin
              last_read = shifter[15:0];
              done_flag = 1'b1;
              pin_cs    = 1'b1;
              bus_phase = PH_IDLE;
            end else begin
              pin_scl   = 1'b1;
              shifter   = {shifter[22:0], req.sda};
              bits_done = bits_done + 5'd1;
              bus_phase = PH_RECV_HIGH;
            end
          end
          PH_RECV_HIGH: begin
            pin_scl   = 1'b0;
            bus_phase = PH_RECV_LOW;
          end
          default: begin
            pin_cs    = 1'b1;
            bus_phase = PH_IDLE;
          end
        endcase
      end
      res.scl       = pin_scl;
      res.sda_out   = pin_sda;
      res.sda_drive = pin_drv;
      res.cs_n      = pin_cs;
      res.busy      = (bus_phase != PH_IDLE);
      res.rdata     = last_read;
      res.rdone     = done_flag;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    tick_req_t  req;
    pin_state_t exp_res;
    if (!rst_n) begin
      bus_phase  = PH_IDLE;
      bits_done  = '0;
      shifter    = '0;
      ticks      = '0;
      half_ticks = HALF_PERIOD_RST;
      last_read  = '0;
      done_flag  = 1'b0;
      reading    = 1'b0;
      pin_scl    = 1'b0;
      pin_sda    = 1'b0;
      pin_drv    = 1'b1;
      pin_cs     = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with none expected, expected nothing, actual scl %0b cs_n %0b",
                   $time, out_scl, out_cs_n);
        end else begin
          exp_res = expected_pins.pop_front();
          check_field("scl", exp_res.scl, out_scl);
          check_field("sda_out", exp_res.sda_out, out_sda_out);
          check_field("sda_drive", exp_res.sda_drive, out_sda_drive);
          check_field("cs_n", exp_res.cs_n, out_cs_n);
          check_field("busy_res", exp_res.busy, out_busy_res);
          check_field("read_data", exp_res.rdata, out_read_data);
          check_field("read_done", exp_res.rdone, out_read_done);
        end
      end
      if (in_valid && !in_stall) begin
        req.start = in_start_req;
        req.kind  = in_kind;
        req.addr  = in_reg_addr;
        req.wdata = in_write_data;
        req.sda   = in_sda_in;
        advance_bus_tick(req, exp_res);
        expected_pins.push_back(exp_res);
      end
      if (cfg_wr_en)
        half_ticks = cfg_wr_data;
    end
  end

  // Receiver: random stalls, or a long counted hold-off when requested
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one tick request and hold it until taken; starts and ends at a falling edge
  task automatic send_tick(input logic start, input logic kind, input logic [6:0] addr,
                           input logic [15:0] wdata, input logic sda);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_kind       <= kind;
    in_reg_addr   <= addr;
    in_write_data <= wdata;
    in_sda_in     <= sda;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every tick has been reported
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_pins.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_half_period(input logic [7:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // One whole register access, then two idle ticks to see the levels held
  task automatic run_access(input logic kind, input logic [6:0] addr, input logic [15:0] wdata,
                            input int sda_mode, input bit busy_starts);
    logic sda;
    sda = (sda_mode == SDA_RANDOM) ? logic'($urandom_range(1)) : (sda_mode == SDA_HIGH);
    send_tick(1'b1, kind, addr, wdata, sda);
    while (bus_phase != PH_IDLE) begin
      sda = (sda_mode == SDA_RANDOM) ? logic'($urandom_range(1)) : (sda_mode == SDA_HIGH);
      send_tick(busy_starts && ($urandom_range(3) == 0), logic'($urandom_range(1)),
                7'($urandom_range(127)), 16'($urandom), sda);
    end
    repeat (2)
      send_tick(1'b0, logic'($urandom_range(1)), 7'($urandom_range(127)), 16'($urandom),
                logic'($urandom_range(1)));
  endtask

  // Random ticks, starts now and then, until the bus model is idle, then two idle ticks
  task automatic finish_access();
    while (bus_phase != PH_IDLE)
      send_tick($urandom_range(3) == 0, logic'($urandom_range(1)), 7'($urandom_range(127)),
                16'($urandom), logic'($urandom_range(1)));
    repeat (2)
      send_tick(1'b0, logic'($urandom_range(1)), 7'($urandom_range(127)), 16'($urandom),
                logic'($urandom_range(1)));
  endtask

  // Reset value of the half period, idle ticks before the first access
  task automatic test_reset_default();
    set_idling(0, 0);
    repeat (3) send_tick(1'b0, KIND_READ, 7'h7f, 16'hffff, 1'b1);
    // first low and high phases at the reset half period, then the rest quickly
    send_tick(1'b1, KIND_WRITE, 7'h55, 16'ha5c3, 1'b0);
    repeat (2 * int'(HALF_PERIOD_RST) + 4)
      send_tick(1'b0, logic'($urandom_range(1)), 7'($urandom_range(127)), 16'($urandom),
                logic'($urandom_range(1)));
    set_half_period(8'd1);
    finish_access();
  endtask

  // Field extremes, both kinds, a zero half period and starts while busy
  task automatic test_directed_accesses();
    set_half_period(8'd0);
    run_access(KIND_WRITE, 7'h7f, 16'hffff, SDA_LOW, 1'b0);
    run_access(KIND_WRITE, 7'h00, 16'h0000, SDA_HIGH, 1'b0);
    run_access(KIND_READ, 7'h7f, 16'h0000, SDA_HIGH, 1'b0);
    run_access(KIND_READ, 7'h00, 16'hffff, SDA_LOW, 1'b0);
    set_half_period(8'd1);
    run_access(KIND_READ, 7'h2a, 16'h1234, SDA_RANDOM, 1'b1);
    run_access(KIND_WRITE, 7'h15, 16'h5aa5, SDA_RANDOM, 1'b1);
  endtask

  // Longest half period: the first low phase runs out, then the read finishes quickly
  task automatic test_longest_half_period();
    set_half_period(8'hff);
    set_idling(0, 0);
    send_tick(1'b1, KIND_READ, 7'h3c, 16'h0000, 1'b1);
    repeat (SLOW_TICKS)
      send_tick($urandom_range(3) == 0, logic'($urandom_range(1)), 7'($urandom_range(127)),
                16'($urandom), logic'($urandom_range(1)));
    set_half_period(8'd1);
    finish_access();
  endtask

  // Receiver holds off while the sender keeps offering, filling the block
  task automatic test_backpressure();
    set_half_period(8'd1);
    set_idling(0, 0);
    hold_toggle <= ~hold_toggle;
    run_access(KIND_WRITE, 7'h61, 16'hc0de, SDA_RANDOM, 1'b1);
    run_access(KIND_READ, 7'h1e, 16'h0000, SDA_RANDOM, 1'b1);
  endtask

  // Random ticks under each idling pattern; starts mostly when the bus is idle
  task automatic test_random_traffic();
    int send_pcts[4] = '{0, 84, 0, 17};
    int recv_pcts[4] = '{0, 0, 84, 17};
    logic start;
    for (int mode = 0; mode < 4; mode++) begin
      for (int sub = 0; sub < 2; sub++) begin
        set_half_period(8'($urandom_range(2)));
        set_idling(send_pcts[mode], recv_pcts[mode]);
        repeat (20) begin
          if (bus_phase == PH_IDLE)
            start = ($urandom_range(99) < 85);
          else
            start = ($urandom_range(99) < 10);
          send_tick(start, logic'($urandom_range(1)), 7'($urandom_range(127)),
                    16'($urandom), logic'($urandom_range(1)));
        end
        // finish the access in flight before the next register write
        while (bus_phase != PH_IDLE)
          send_tick(1'b0, logic'($urandom_range(1)), 7'($urandom_range(127)),
                    16'($urandom), logic'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int waited;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_start_req  = 1'b0;
    in_kind       = KIND_WRITE;
    in_reg_addr   = '0;
    in_write_data = '0;
    in_sda_in     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_default();
    test_directed_accesses();
    test_longest_half_period();
    test_backpressure();
    test_random_traffic();

    // drain whatever is still in flight
    set_idling(0, 0);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_pins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_pins.size() != 0) begin
      mismatch_count += expected_pins.size();
      $display("%0t ns: results missing, expected %0d more, actual 0", $time,
               expected_pins.size());
    end
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
